FILE: rtl/core/twbl_pkg.sv
// twbl_pkg: shared types and constants of the time/weather bilinear colour lookup.
// No dependencies; imported by every module of the block.
`default_nettype none

package twbl_pkg;

  // table geometry
  localparam int HOURS         = 24;
  localparam int WEATHER_KINDS = 32;
  localparam int MEM_DEPTH     = HOURS * WEATHER_KINDS;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);

  // field widths
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int WX_W    = 5;
  localparam int BLEND_W = 9;
  localparam int VALUE_W = 32;
  localparam int CHAN_W  = 8;
  localparam int CHANS   = 4;
  localparam int OUT_W   = 16;

  // function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // weights
  localparam int MIN_SECS   = 60;
  localparam int TIME_FULL  = 3600;
  localparam int BLEND_FULL = 256;
  localparam int T_W        = 12;
  localparam int COEF_W     = 20;
  localparam int READS      = 4;
  localparam int STEP_W     = 2;

  // accumulate and divide by 3600 = 16 * 225
  localparam int PROD_W      = CHAN_W + COEF_W;
  localparam int ACC_W       = 28;
  localparam int ROUND_BIAS  = TIME_FULL / 2;
  localparam int DIV_SHIFT   = 4;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP       = 19088744;
  localparam int QP_W        = RECIP_SHIFT + OUT_W;

  // queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic               func;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [MIN_W-1:0]   second;
    logic [WX_W-1:0]    weather_a;
    logic [WX_W-1:0]    weather_b;
    logic [BLEND_W-1:0] blend;
    logic [VALUE_W-1:0] entry_value;
  } twbl_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic [OUT_W-1:0] alpha;
  } twbl_out_t;

  // command handed from front to back; a write uses addr[0] and value
  typedef struct packed {
    logic                          is_query;
    logic [READS-1:0][ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0]            value;
    logic [T_W-1:0]                t;
    logic [BLEND_W-1:0]            b;
  } twbl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/twbl_front.sv
// twbl_front: accepts input words, wraps the hour, clamps other fields, forms addresses
// and weights, and holds commands in a short queue for the back end. Uses twbl_pkg.
`default_nettype none

module twbl_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire twbl_pkg::twbl_in_t in_data,
  output logic                    cmd_valid,
  output twbl_pkg::twbl_cmd_t     cmd,
  input  wire logic               cmd_pop
);
  import twbl_pkg::*;

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {KIND_DROP, KIND_WRITE, KIND_QUERY} kind_t;

  function automatic logic [WX_W-1:0] clamp_wx(input logic [WX_W-1:0] w);
    if (32'(w) >= WEATHER_KINDS) return WX_W'(WEATHER_KINDS - 1);
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [HOUR_W-1:0] h,
                                                input logic [WX_W-1:0] w);
    return ADDR_W'(32'(h) * WEATHER_KINDS + 32'(w));
  endfunction

  kind_t               kind;
  logic [HOUR_W-1:0]   h1, h2;
  logic [WX_W-1:0]     w1, w2;
  logic [T_W-1:0]      t_raw, t_sat;
  logic [BLEND_W-1:0]  b_sat;
  logic                write_ok;
  logic                enq;
  twbl_cmd_t           new_cmd;

  twbl_cmd_t           q_mem [CMDQ_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  always_comb begin
    h1 = (in_data.hour >= HOUR_W'(HOURS)) ? in_data.hour - HOUR_W'(HOURS) : in_data.hour;
    h2 = (h1 == HOUR_W'(HOURS - 1)) ? '0 : h1 + 1'b1;
    w1 = clamp_wx(in_data.weather_a);
    w2 = clamp_wx(in_data.weather_b);

    t_raw = T_W'(in_data.minute) * T_W'(MIN_SECS) + T_W'(in_data.second);
    t_sat = (t_raw > T_W'(TIME_FULL)) ? T_W'(TIME_FULL) : t_raw;
    b_sat = (in_data.blend > BLEND_W'(BLEND_FULL)) ? BLEND_W'(BLEND_FULL) : in_data.blend;

    write_ok = (32'(in_data.hour) < HOURS) && (32'(in_data.weather_a) < WEATHER_KINDS);

    unique case (in_data.func)
      FUNC_QUERY: kind = KIND_QUERY;
      FUNC_WRITE: kind = write_ok ? KIND_WRITE : KIND_DROP;
      default:    kind = KIND_DROP;
    endcase

    // a legal write has h1 == hour and w1 == weather_a, so addr[0] serves both
    new_cmd.is_query = (kind == KIND_QUERY);
    new_cmd.addr[0]  = addr_of(h1, w1);
    new_cmd.addr[1]  = addr_of(h2, w1);
    new_cmd.addr[2]  = addr_of(h1, w2);
    new_cmd.addr[3]  = addr_of(h2, w2);
    new_cmd.value    = in_data.entry_value;
    new_cmd.t        = t_sat;
    new_cmd.b        = b_sat;
  end

  assign full      = (count_r == CNT_W'(CMDQ_DEPTH));
  assign enq       = push && !full && (kind != KIND_DROP);
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (enq) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (cmd_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + CNT_W'(enq) - CNT_W'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/twbl_outq.sv
// twbl_outq: result queue in front of the output port; space is reserved upstream
// before a query starts. Uses twbl_pkg.
`default_nettype none

module twbl_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_push,
  input  wire twbl_pkg::twbl_out_t res_data,
  output logic                     empty,
  input  wire logic                pop,
  output twbl_pkg::twbl_out_t      out_data
);
  import twbl_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  twbl_out_t        q_mem [OUTQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             deq;

  assign empty    = (count_r == '0);
  assign deq      = pop && !empty;
  assign out_data = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_mem[wr_ptr_r] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (res_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (deq) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + CNT_W'(res_push) - CNT_W'(deq);
    end
  end

  // upstream reservation must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (count_r != CNT_W'(OUTQ_DEPTH)) || deq)
    else $error("result queue overflow");

endmodule

`default_nettype wire

FILE: rtl/core/twbl_back.sv
// twbl_back: colour table memory, read sequencer and blend/divide pipeline.
// Takes commands from twbl_front, pushes results into twbl_outq. Uses twbl_pkg.
`default_nettype none

module twbl_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  input  wire twbl_pkg::twbl_cmd_t cmd,
  output logic                     cmd_pop,
  input  wire logic                res_taken,
  output logic                     res_push,
  output twbl_pkg::twbl_out_t      res_data
);
  import twbl_pkg::*;

  localparam int PEND_W = $clog2(OUTQ_DEPTH + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(READS - 1);

  logic [VALUE_W-1:0] colour_mem [MEM_DEPTH];
  logic [VALUE_W-1:0] rdata_r;
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;

  twbl_cmd_t          cur_r;
  logic               busy_r;
  logic [STEP_W-1:0]  step_r;
  logic [PEND_W-1:0]  pending_r;

  logic               idle_slot, take_query, take_write;
  logic [T_W-1:0]     t_op;
  logic [BLEND_W-1:0] b_op;

  logic               s1_v_r, s1_first_r, s1_last_r;
  logic [COEF_W-1:0]  coef_r;
  logic               s2_v_r, s2_first_r, s2_last_r;
  logic [PROD_W-1:0]  prod_r [CHANS];
  logic [ACC_W-1:0]   acc_r  [CHANS];
  logic               s3_v_r;
  logic [QP_W-1:0]    qp_r   [CHANS];
  logic               s4_v_r;

  always_comb begin
    idle_slot  = !busy_r || (step_r == STEP_LAST);
    take_query = cmd_valid && cmd.is_query && idle_slot &&
                 (pending_r < PEND_W'(OUTQ_DEPTH));
    // writes use the port only while no read sequence runs
    take_write = cmd_valid && !cmd.is_query && !busy_r;
    cmd_pop    = take_query || take_write;
    mem_we     = take_write;
    mem_addr   = take_write ? cmd.addr[0] : cur_r.addr[step_r];
    // step bit 0 picks next hour, bit 1 picks new weather
    t_op = step_r[0] ? cur_r.t : T_W'(TIME_FULL) - cur_r.t;
    b_op = step_r[1] ? cur_r.b : BLEND_W'(BLEND_FULL) - cur_r.b;
  end

  // single port table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      colour_mem[mem_addr] <= cmd.value;
    end
    rdata_r <= colour_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      step_r    <= '0;
      pending_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
    end else begin
      if (take_query) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        busy_r <= (step_r != STEP_LAST);
        step_r <= step_r + 1'b1;
      end
      pending_r <= pending_r + PEND_W'(take_query) - PEND_W'(res_taken);
      s1_v_r    <= busy_r;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r && s2_last_r;
      s4_v_r    <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_query) begin
      cur_r <= cmd;
    end
    // read issue: coefficient for this corner
    coef_r     <= COEF_W'(COEF_W'(t_op) * COEF_W'(b_op));
    s1_first_r <= (step_r == '0);
    s1_last_r  <= (step_r == STEP_LAST);
    // data back: weight each channel
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    for (int c = 0; c < CHANS; c++) begin
      prod_r[c] <= PROD_W'(rdata_r[CHAN_W*(CHANS-1-c) +: CHAN_W]) * PROD_W'(coef_r);
    end
    // accumulate, seeded with the rounding bias
    if (s2_v_r) begin
      for (int c = 0; c < CHANS; c++) begin
        acc_r[c] <= (s2_first_r ? ACC_W'(ROUND_BIAS) : acc_r[c]) + ACC_W'(prod_r[c]);
      end
    end
    // divide by 3600: drop four bits, then multiply by reciprocal of 225
    for (int c = 0; c < CHANS; c++) begin
      qp_r[c] <= QP_W'(acc_r[c][ACC_W-1:DIV_SHIFT]) * QP_W'(RECIP);
    end
  end

  assign res_push       = s4_v_r;
  assign res_data.red   = qp_r[0][RECIP_SHIFT +: OUT_W];
  assign res_data.green = qp_r[1][RECIP_SHIFT +: OUT_W];
  assign res_data.blue  = qp_r[2][RECIP_SHIFT +: OUT_W];
  assign res_data.alpha = qp_r[3][RECIP_SHIFT +: OUT_W];

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PEND_W'(OUTQ_DEPTH))
    else $error("more queries in flight than result slots");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    take_query |=> busy_r && (step_r == '0))
    else $error("query taken but read sequence did not start");

  a_step_flow: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (step_r != STEP_LAST) |=> busy_r && (step_r == $past(step_r) + 1'b1))
    else $error("read sequence broke off early");

  a_result_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (pending_r != '0))
    else $error("result produced without a reservation");

endmodule

`default_nettype wire

FILE: rtl/core/time_weather_bilinear_lut.sv
// Colour lookup indexed by hour (24 rows) and weather kind, with bilinear blend of four
// entries per query; results are four channels in unsigned 8.8 fixed point. A write
// word makes one access of the table port; a query makes four, one per table read.
// A new query can start once the previous one issues its last read, if a result slot
// is free; the single-port table serialises the reads. Up to four commands queue
// behind the input and up to four results wait at the output. The table has no reset
// or clearing pass: every entry a query touches must have been written first.
// Out-of-range writes are dropped.
`default_nettype none

module time_weather_bilinear_lut (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire twbl_pkg::twbl_in_t  in_data,
  output logic                     empty,
  input  wire logic                pop,
  output twbl_pkg::twbl_out_t      out_data
);
  import twbl_pkg::*;

  logic      cmd_valid, cmd_pop;
  twbl_cmd_t cmd;
  logic      res_push, res_taken;
  twbl_out_t res_data;

  assign res_taken = pop && !empty;

  twbl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  twbl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_taken (res_taken),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  twbl_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
